@@ rtl/sfmt19937_generator_core_macros.svh @@
// Assertion macros shared by the generator RTL.
`ifndef SFMT19937_GENERATOR_CORE_MACROS_SVH
`define SFMT19937_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define SFMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SFMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sfmt_pkg.sv @@
// Constants, codes and helper functions of the SFMT-19937 generator.
package sfmt_pkg;

  localparam int STATE_WORDS = 156;
  localparam int PICK_OFFSET = 122;
  localparam int LANES_TOTAL = STATE_WORDS * 4;
  localparam int IDX_W       = $clog2(STATE_WORDS);
  localparam int LANE_CNT_W  = $clog2(LANES_TOTAL);
  localparam int LANE_SL     = 18;
  localparam int LANE_SR     = 11;
  localparam int BYTE_SHIFT  = 8;

  localparam logic [31:0]  SEED_MULT  = 32'd1812433253;
  localparam logic [127:0] LANE_MASK  = {32'hbffffff6, 32'hbffaffff,
                                         32'hddfecb7f, 32'hdfffffef};
  localparam logic [127:0] PARITY_VEC = {32'h13c9e684, 32'h00000000,
                                         32'h00000000, 32'h00000001};

  localparam logic OP_NEXT   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  localparam logic [1:0] STATUS_RAND     = 2'd0;
  localparam logic [1:0] STATUS_SEEDED   = 2'd1;
  localparam logic [1:0] STATUS_UNSEEDED = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MUL     = 9'b000000010,
    ST_ADD     = 9'b000000100,
    ST_CERT_RD = 9'b000001000,
    ST_CERT_WR = 9'b000010000,
    ST_RD_A    = 9'b000100000,
    ST_RD_B    = 9'b001000000,
    ST_CALC    = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_t;

  function automatic logic [127:0] regen_word(input logic [127:0] a, input logic [127:0] b,
                                              input logic [127:0] c, input logic [127:0] d);
    logic [127:0] bsr;
    logic [127:0] dsl;
    for (int l = 0; l < 4; l++) begin
      bsr[32*l +: 32] = b[32*l +: 32] >> LANE_SR;
      dsl[32*l +: 32] = d[32*l +: 32] << LANE_SL;
    end
    return a ^ (a << BYTE_SHIFT) ^ (bsr & LANE_MASK) ^ (c >> BYTE_SHIFT) ^ dsl;
  endfunction

endpackage

@@ rtl/sfmt19937_generator_core.sv @@
// SFMT-19937 generator core: seeded 156 x 128-bit state store, one word per next beat.
// A next beat reads the current word and the word 122 ahead through the store's single read
// port, one after the other, then the new word is formed and written back; the two
// previously written words sit in registers. A reseed beat runs the seed recurrence
// over 623 lanes on the shared 32x32 multiplier, a multiply state and an add state per
// lane, then word 0 is read back and certified before its answer.
// One beat is in work at a time; in_tready is high only when no result is pending.
`include "sfmt19937_generator_core_macros.svh"

module sfmt19937_generator_core
  import sfmt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] seed
  input  logic         in_tuser,   // [0] opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] rand_low, [127:64] rand_high
  output logic [1:0]   out_tuser   // [1:0] status
);

  state_t state_r, state_nxt;

  logic [127:0] mem [STATE_WORDS];
  logic [127:0] rdata_r;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [127:0] wdata;
  logic mem_we;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic seeded_r, seeded_nxt;
  logic [LANE_CNT_W-1:0] k_r, k_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [127:0] wbuf_r, wbuf_nxt;
  logic [127:0] a_r, a_nxt;
  logic [127:0] c_r, c_nxt;
  logic [127:0] d_r, d_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  logic [IDX_W:0] pick_sum;
  logic [IDX_W-1:0] pick_idx;
  logic [31:0] lane_val;
  logic [127:0] fill_word;
  logic [127:0] new_word;
  logic parity_odd;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  assign pick_sum = {1'b0, idx_r} + (IDX_W+1)'(PICK_OFFSET);
  assign pick_idx = (pick_sum >= (IDX_W+1)'(STATE_WORDS))
                    ? IDX_W'(pick_sum - (IDX_W+1)'(STATE_WORDS)) : pick_sum[IDX_W-1:0];

  assign lane_val   = prod_r + 32'(k_r);
  assign fill_word  = {lane_val, wbuf_r[95:0]};
  assign new_word   = regen_word(a_r, rdata_r, c_r, d_r);
  assign parity_odd = ^(rdata_r & PARITY_VEC);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    seeded_nxt     = seeded_r;
    k_nxt          = k_r;
    prev_nxt       = prev_r;
    prod_nxt       = prod_r;
    wbuf_nxt       = wbuf_r;
    a_nxt          = a_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    raddr          = idx_r;
    waddr          = idx_r;
    wdata          = new_word;
    mem_we         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          priority if (in_tuser == OP_RESEED) begin
            prev_nxt          = in_tdata;
            wbuf_nxt[31:0]    = in_tdata;
            k_nxt             = LANE_CNT_W'(1);
            state_nxt         = ST_MUL;
          end else if (seeded_r) begin
            state_nxt         = ST_RD_A;
          end else begin
            out_data_nxt      = '0;
            out_status_nxt    = STATUS_UNSEEDED;
            out_valid_nxt     = 1'b1;
            state_nxt         = ST_OUT;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = SEED_MULT * (prev_r ^ (prev_r >> 30));
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        prev_nxt                   = lane_val;
        wbuf_nxt[32*k_r[1:0] +: 32] = lane_val;
        if (k_r[1:0] == 2'd3) begin
          mem_we = 1'b1;
          waddr  = k_r[LANE_CNT_W-1:2];
          wdata  = fill_word;
          c_nxt  = d_r;
          d_nxt  = fill_word;
        end
        if (k_r == LANE_CNT_W'(LANES_TOTAL - 1)) begin
          state_nxt = ST_CERT_RD;
        end else begin
          k_nxt     = k_r + LANE_CNT_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_CERT_RD: begin
        raddr     = '0;
        state_nxt = ST_CERT_WR;
      end
      ST_CERT_WR: begin
        mem_we         = 1'b1;
        waddr          = '0;
        wdata          = {rdata_r[127:1], rdata_r[0] ^ ~parity_odd};
        idx_nxt        = '0;
        seeded_nxt     = 1'b1;
        out_data_nxt   = '0;
        out_status_nxt = STATUS_SEEDED;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_RD_A: begin
        raddr     = idx_r;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        raddr     = pick_idx;
        a_nxt     = rdata_r;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        mem_we         = 1'b1;
        waddr          = idx_r;
        wdata          = new_word;
        c_nxt          = d_r;
        d_nxt          = new_word;
        idx_nxt        = (idx_r == IDX_W'(STATE_WORDS - 1)) ? '0 : idx_r + IDX_W'(1);
        out_data_nxt   = new_word;
        out_status_nxt = STATUS_RAND;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    prod_r       <= prod_nxt;
    wbuf_r       <= wbuf_nxt;
    a_r          <= a_nxt;
    c_r          <= c_nxt;
    d_r          <= d_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  `SFMT_ASSERT_NOW(a_ready_no_pending, in_tready, !out_tvalid, "input ready while a result is pending")
  `SFMT_ASSERT_NOW(a_idx_range, 1'b1, idx_r < IDX_W'(STATE_WORDS), "next index out of range")
  `SFMT_ASSERT_NOW(a_fill_write_aligned, (state_r == ST_ADD) && mem_we, k_r[1:0] == 2'd3, "fill write before a word is complete")
  `SFMT_ASSERT_NOW(a_rand_needs_seed, out_tvalid && (out_tuser == STATUS_RAND), seeded_r, "random word returned while unseeded")
  `SFMT_ASSERT_NEXT(a_calc_to_out, state_r == ST_CALC, out_tvalid && (out_tuser == STATUS_RAND), "regenerated word not presented")

endmodule

@@ test/sfmt19937_generator_core_tb.sv @@
// Self-checking testbench for the SFMT-19937 generator core with a shadow state predictor.
`timescale 1ns / 100ps

module sfmt19937_generator_core_tb
  import sfmt_pkg::*;
;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 8000;
  localparam int DRAIN_WAIT  = 16;

  class sfmt_scoreboard;
    logic [127:0] shadow_words [STATE_WORDS];
    int unsigned  word_ptr;
    bit           seeded;
    logic [127:0] pending_words [$];
    logic [1:0]   pending_status [$];
    int           fails;

    function new();
      word_ptr = 0;
      seeded   = 1'b0;
      fails    = 0;
    endfunction

    function void reseed(logic [31:0] seed);
      logic [31:0] lane;
      lane = seed;
      shadow_words[0][31:0] = seed;
      for (int k = 1; k < LANES_TOTAL; k++) begin
        lane = SEED_MULT * (lane ^ (lane >> 30)) + k;
        shadow_words[k / 4][32 * (k % 4) +: 32] = lane;
      end
      // certify: even parity over the check lanes flips bit 0 of lane u0
      if ((^(shadow_words[0] & PARITY_VEC)) == 1'b0)
        shadow_words[0][0] = ~shadow_words[0][0];
      word_ptr = 0;
      seeded   = 1'b1;
    endfunction

    function logic [127:0] next_word();
      logic [127:0] cur, ahead, older, newest, fresh;
      cur    = shadow_words[word_ptr];
      ahead  = shadow_words[(word_ptr + PICK_OFFSET) % STATE_WORDS];
      older  = shadow_words[(word_ptr + STATE_WORDS - 2) % STATE_WORDS];
      newest = shadow_words[(word_ptr + STATE_WORDS - 1) % STATE_WORDS];
      for (int l = 0; l < 4; l++) begin
        fresh[32 * l +: 32] = cur[32 * l +: 32]
                            ^ ((ahead[32 * l +: 32] >> LANE_SR) & LANE_MASK[32 * l +: 32])
                            ^ (newest[32 * l +: 32] << LANE_SL);
      end
      fresh = fresh ^ {cur[119:0], 8'h00} ^ {8'h00, older[127:8]};
      shadow_words[word_ptr] = fresh;
      word_ptr = (word_ptr + 1) % STATE_WORDS;
      return fresh;
    endfunction

    function void note_beat(logic op, logic [31:0] seed);
      if (op == OP_RESEED) begin
        reseed(seed);
        pending_words.push_back('0);
        pending_status.push_back(STATUS_SEEDED);
      end else if (!seeded) begin
        pending_words.push_back('0);
        pending_status.push_back(STATUS_UNSEEDED);
      end else begin
        pending_words.push_back(next_word());
        pending_status.push_back(STATUS_RAND);
      end
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fails++;
    endtask

    task check_beat(logic [127:0] data, logic [1:0] status);
      logic [127:0] word;
      logic [1:0]   stat;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected result beat data=%h status=%0d", data, status));
        return;
      end
      word = pending_words.pop_front();
      stat = pending_status.pop_front();
      if (data[63:0] !== word[63:0])
        report($sformatf("rand_low got %h want %h", data[63:0], word[63:0]));
      if (data[127:64] !== word[127:64])
        report($sformatf("rand_high got %h want %h", data[127:64], word[127:64]));
      if (status !== stat)
        report($sformatf("status got %0d want %0d", status, stat));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;

  sfmt_scoreboard sb = new();
  bit hold_off_req = 1'b0;
  int burst_left   = 0;
  int idle_cycles  = 0;

  sfmt19937_generator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_beat(input logic op, input logic [31:0] seed);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= seed;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, seed);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer(input logic op, input logic [31:0] seed);
    send_beat(op, seed);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9));
    end
  endtask

  task automatic drain();
    idle_gap(1);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // check results and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_beat(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : receiver
    int mode, left, phase;
    left  = 0;
    phase = 0;
    mode  = 0;
    out_tready = 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 150);
        end
        left--;
        phase++;
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_tready <= ($urandom_range(0, 1) != 0);
          end
          default: begin
            out_tready <= (phase % 5 != 0) && (phase % 7 != 3);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int run_len;
    int sent;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_NEXT;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // next before any seed
    offer(OP_NEXT, 32'h0000_0000);
    offer(OP_NEXT, 32'hffff_ffff);
    offer(OP_NEXT, $urandom);
    offer(OP_RESEED, 32'h0000_0000);
    repeat (4) offer(OP_NEXT, $urandom);
    offer(OP_RESEED, 32'hffff_ffff);
    repeat (3) offer(OP_NEXT, $urandom);
    offer(OP_RESEED, 32'h0000_0001);
    repeat (2) offer(OP_NEXT, 32'hffff_ffff);
    offer(OP_RESEED, 32'h8000_0000);
    repeat (2) offer(OP_NEXT, 32'h0000_0000);
    offer(OP_RESEED, 32'd5489);
    repeat (2) offer(OP_NEXT, $urandom);

    // pause until every result is back
    drain();

    // hold the receiver off while beats keep coming
    hold_off_req = 1'b1;
    repeat (40) offer(OP_NEXT, $urandom);

    sent = 0;
    while (sent < 740) begin
      offer(OP_RESEED, $urandom);
      sent++;
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(157, 330) : $urandom_range(0, 60);
      repeat (run_len) begin
        offer(OP_NEXT, $urandom);
        sent++;
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
